[sv/fprm_pkg.sv]
package fprm_pkg;

  localparam int WINDOW_DEPTH = 512;
  localparam int TICK_BITS = 24;
  localparam int SLOT_BITS = $clog2(WINDOW_DEPTH);
  localparam int FILL_BITS = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_BITS = TICK_BITS + SLOT_BITS;
  localparam int RATE_BITS = 32;
  localparam int FRAME_BITS = 32;
  localparam int DIVIDEND_BITS = TICK_BITS + 8;
  localparam int DIV_BITS = (SUM_BITS > DIVIDEND_BITS) ? SUM_BITS : DIVIDEND_BITS;
  localparam int STEP_BITS = $clog2(DIV_BITS);
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;

  localparam logic [TICK_BITS-1:0] MIN_FRAME_RESET = TICK_BITS'(16666);
  localparam logic [TICK_BITS-1:0] TICK_RATE_RESET = TICK_BITS'(1000000);

  localparam logic REG_MIN_FRAME = 1'b0;
  localparam logic REG_TICK_RATE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_UPDATE = 4'b0010,
    ST_DIVIDE = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

endpackage

[sv/frame_pacer_rate_meter.sv]
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_ready   elapsed_ticks
// result    out        out_valid/out_ready frame_delta, wait_ticks, rate_q8, mean_delta,
//                                          window_fill, frame_number
// config    in/out     APB psel/penable    paddr, pwdata, prdata (min_frame_ticks, tick_rate)
//
// The oldest delta is read from the ring memory as a word is accepted; the update state then
// writes the new delta and updates the running sum, the divide state runs the rate and mean
// restoring dividers, and the finish state loads the result register. The next word is
// accepted only after the block returns to idle.
// A new word is accepted while a finished result still waits in the output register.
// Reset is synchronous; it clears the counters and the running sum and restores the
// configuration defaults.
// A stalled result holds the block in its finish state until the output register frees.
module frame_pacer_rate_meter
  import fprm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TICK_BITS-1:0]  elapsed_ticks,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TICK_BITS-1:0]  frame_delta,
  output logic [TICK_BITS-1:0]  wait_ticks,
  output logic [RATE_BITS-1:0]  rate_q8,
  output logic [TICK_BITS-1:0]  mean_delta,
  output logic [FILL_BITS-1:0]  window_fill,
  output logic [FRAME_BITS-1:0] frame_number,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_BITS-1:0]  paddr,
  input  logic [DATA_BITS-1:0]  pwdata,
  output logic [DATA_BITS-1:0]  prdata,
  output logic                  pready
);

  logic [TICK_BITS-1:0]  ring [WINDOW_DEPTH];
  logic [TICK_BITS-1:0]  ring_rd;

  state_t                state;
  logic [TICK_BITS-1:0]  min_frame_ticks;
  logic [TICK_BITS-1:0]  tick_rate;
  logic [SLOT_BITS-1:0]  write_slot;
  logic [FILL_BITS-1:0]  fill_count;
  logic [SUM_BITS-1:0]   window_sum;
  logic [FRAME_BITS-1:0] frames_done;
  logic [TICK_BITS-1:0]  delta;
  logic [TICK_BITS-1:0]  wait_amt;
  logic [STEP_BITS-1:0]  step;

  logic [DIV_BITS-1:0]   rate_q;
  logic [TICK_BITS-1:0]  rate_r;
  logic [DIV_BITS-1:0]   mean_q;
  logic [FILL_BITS-1:0]  mean_r;

  logic                  in_take;
  logic                  cfg_write;
  logic                  window_full;
  logic [SUM_BITS-1:0]   window_sum_next;
  logic [FILL_BITS-1:0]  fill_count_next;
  logic [SLOT_BITS-1:0]  write_slot_next;
  logic [TICK_BITS:0]    rate_trial;
  logic [TICK_BITS:0]    rate_diff;
  logic [FILL_BITS:0]    mean_trial;
  logic [FILL_BITS:0]    mean_diff;
  logic                  out_free;

  assign in_ready  = (state == ST_IDLE);
  assign in_take   = in_valid && in_ready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign out_free  = !out_valid || out_ready;

  assign window_full = (fill_count >= FILL_BITS'(WINDOW_DEPTH));

  always_comb begin
    window_sum_next = window_sum + SUM_BITS'(delta);
    if (window_full) begin
      window_sum_next = window_sum_next - SUM_BITS'(ring_rd);
    end
    fill_count_next = window_full ? fill_count : fill_count + FILL_BITS'(1);
    write_slot_next = (write_slot == SLOT_BITS'(WINDOW_DEPTH - 1)) ? '0
                                                                   : write_slot + SLOT_BITS'(1);
  end

  always_comb begin
    rate_trial = {rate_r, rate_q[DIV_BITS-1]};
    rate_diff  = rate_trial - {1'b0, delta};
    mean_trial = {mean_r, mean_q[DIV_BITS-1]};
    mean_diff  = mean_trial - {1'b0, fill_count};
  end

  always_comb begin
    case (paddr[2])
      REG_MIN_FRAME: prdata = DATA_BITS'(min_frame_ticks);
      REG_TICK_RATE: prdata = DATA_BITS'(tick_rate);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ring_rd <= ring[write_slot];
    end
    if (state == ST_UPDATE) begin
      ring[write_slot] <= delta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_frame_ticks <= MIN_FRAME_RESET;
      tick_rate       <= TICK_RATE_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_MIN_FRAME: min_frame_ticks <= pwdata[TICK_BITS-1:0];
        REG_TICK_RATE: tick_rate <= pwdata[TICK_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      if (elapsed_ticks < min_frame_ticks) begin
        delta    <= min_frame_ticks;
        wait_amt <= min_frame_ticks - elapsed_ticks;
      end else begin
        delta    <= elapsed_ticks;
        wait_amt <= '0;
      end
    end
    case (state)
      ST_UPDATE: begin
        rate_q <= DIV_BITS'({tick_rate, 8'd0});
        rate_r <= '0;
        mean_q <= DIV_BITS'(window_sum_next);
        mean_r <= '0;
      end
      ST_DIVIDE: begin
        if (!rate_diff[TICK_BITS]) begin
          rate_r <= rate_diff[TICK_BITS-1:0];
          rate_q <= {rate_q[DIV_BITS-2:0], 1'b1};
        end else begin
          rate_r <= rate_trial[TICK_BITS-1:0];
          rate_q <= {rate_q[DIV_BITS-2:0], 1'b0};
        end
        if (!mean_diff[FILL_BITS]) begin
          mean_r <= mean_diff[FILL_BITS-1:0];
          mean_q <= {mean_q[DIV_BITS-2:0], 1'b1};
        end else begin
          mean_r <= mean_trial[FILL_BITS-1:0];
          mean_q <= {mean_q[DIV_BITS-2:0], 1'b0};
        end
      end
      default: ;
    endcase
    if (state == ST_FINISH && out_free) begin
      frame_delta  <= delta;
      wait_ticks   <= wait_amt;
      rate_q8      <= (delta == '0) ? '0 : rate_q[RATE_BITS-1:0];
      mean_delta   <= mean_q[TICK_BITS-1:0];
      window_fill  <= fill_count;
      frame_number <= frames_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      write_slot  <= '0;
      fill_count  <= '0;
      window_sum  <= '0;
      frames_done <= '0;
      step        <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          window_sum  <= window_sum_next;
          fill_count  <= fill_count_next;
          write_slot  <= write_slot_next;
          frames_done <= frames_done + FRAME_BITS'(1);
          step        <= '0;
          state       <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          step <= step + STEP_BITS'(1);
          if (step == STEP_BITS'(DIV_BITS - 1)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_BITS'(WINDOW_DEPTH))
    else $error("Fill count exceeds the window depth.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (window_fill != '0 && window_fill <= FILL_BITS'(WINDOW_DEPTH)))
    else $error("Result carries an impossible window fill.");

  assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == ST_UPDATE))
    else $error("Accepted word did not start the ring update.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (wait_ticks == '0 || frame_delta == min_frame_ticks))
    else $error("Stretched frame does not match the minimum frame time.");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |=> (frames_done == $past(frames_done) + FRAME_BITS'(1)))
    else $error("Frame counter did not advance on the update cycle.");

endmodule
